>>> hdl/rpr_pkg.sv
// Shared types and constants for the record peak-to-peak and RMS block.
package rpr_pkg;

    localparam int SAMPLE_W = 12;
    localparam int LOW_W    = 13;
    localparam int TOTAL_W  = 34;
    localparam int COUNT_W  = 10;
    localparam int MEAN_W   = 24;
    localparam int REM_W    = COUNT_W + 1;
    localparam int STEP_W   = $clog2(TOTAL_W);
    localparam int BIT_W    = $clog2(SAMPLE_W);

    localparam logic [LOW_W-1:0] LOW_RESET = LOW_W'(4096);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] peak_to_peak;
        logic [SAMPLE_W-1:0] rms_value;
        logic                record_too_long;
    } t_out_item;

    // One finished record handed from the accumulator to the back end.
    typedef struct packed {
        logic [SAMPLE_W-1:0] p2p;
        logic [TOTAL_W-1:0]  total;
        logic [COUNT_W-1:0]  count;
        logic                too_long;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_ROOT,
        BK_WRITE
    } t_back_state;

endpackage

>>> hdl/rpr_fifo.sv
// Two-entry queue used between the pipeline parts and at the result port.
module rpr_fifo
    import rpr_pkg::*;
#(
    parameter type t_data = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_data o_data,
    output logic  o_empty
);

    t_data       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    logic        n_wr_ptr;
    logic        n_rd_ptr;
    logic [1:0]  n_count;
    logic        do_push;
    logic        do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> hdl/rpr_front.sv
// Record accumulator: running minimum, maximum, sum of squares and count.
module rpr_front
    import rpr_pkg::*;
#(
    parameter int MAX_SAMPLES = 512
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_job_push,
    output t_job     o_job
);

    logic [LOW_W-1:0]    r_low;
    logic [SAMPLE_W-1:0] r_high;
    logic [TOTAL_W-1:0]  r_total;
    logic [COUNT_W-1:0]  r_count;
    logic                r_over;

    logic [LOW_W-1:0]    n_low;
    logic [SAMPLE_W-1:0] n_high;
    logic [TOTAL_W-1:0]  n_total;
    logic [COUNT_W-1:0]  n_count;
    logic                n_over;

    logic                take;
    logic [MEAN_W-1:0]   square;
    logic [SAMPLE_W-1:0] s;

    assign s      = i_item.sample;
    assign take   = (r_count < COUNT_W'(MAX_SAMPLES));
    assign square = s * s;

    always_comb begin
        n_low   = r_low;
        n_high  = r_high;
        n_total = r_total;
        n_count = r_count;
        n_over  = r_over;
        if (take) begin
            if ({1'b0, s} < r_low) begin
                n_low = {1'b0, s};
            end
            if (s > r_high) begin
                n_high = s;
            end
            n_total = r_total + TOTAL_W'(square);
            n_count = r_count + COUNT_W'(1);
        end else begin
            n_over = 1'b1;
        end
    end

    // The job carries the state as it stands after this last sample.
    always_comb begin
        o_job_push     = i_accept && i_item.last;
        o_job.p2p      = '0;
        if ({1'b0, n_high} >= n_low) begin
            o_job.p2p = n_high - n_low[SAMPLE_W-1:0];
        end
        o_job.total    = n_total;
        o_job.count    = n_count;
        o_job.too_long = n_over;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_job_push) begin
            r_low   <= LOW_RESET;
            r_high  <= '0;
            r_total <= '0;
            r_count <= '0;
            r_over  <= 1'b0;
        end else if (i_accept) begin
            r_low   <= n_low;
            r_high  <= n_high;
            r_total <= n_total;
            r_count <= n_count;
            r_over  <= n_over;
        end
    end

endmodule

>>> hdl/rpr_back.sv
// Back end: restoring divide for the mean, then a bit-by-bit square root.
module rpr_back
    import rpr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_job_pop,
    input  logic      i_out_full,
    output logic      o_out_push,
    output t_out_item o_out_data
);

    t_back_state         r_state;
    t_back_state         n_state;

    logic [TOTAL_W-1:0]  r_quo;
    logic [REM_W-1:0]    r_rem;
    logic [COUNT_W-1:0]  r_div;
    logic [STEP_W-1:0]   r_step;
    logic [SAMPLE_W-1:0] r_root;
    logic [BIT_W-1:0]    r_bit;
    logic [SAMPLE_W-1:0] r_p2p;
    logic                r_too_long;
    logic                r_zero;

    logic [TOTAL_W-1:0]  n_quo;
    logic [REM_W-1:0]    n_rem;
    logic [STEP_W-1:0]   n_step;
    logic [SAMPLE_W-1:0] n_root;
    logic [BIT_W-1:0]    n_bit;

    logic [REM_W-1:0]    rem_sh;
    logic                rem_ge;
    logic [SAMPLE_W-1:0] trial;
    logic [MEAN_W-1:0]   trial_sq;

    // One quotient bit per cycle; the dividend shifts out as the quotient
    // shifts in, so r_quo holds the quotient when the divide finishes.
    assign rem_sh   = {r_rem[REM_W-2:0], r_quo[TOTAL_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_div});
    assign trial    = r_root | (SAMPLE_W'(1) << r_bit);
    assign trial_sq = trial * trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_step = r_step;
        n_root = r_root;
        n_bit  = r_bit;
        case (r_state)
            BK_IDLE: begin
                n_quo  = i_job.total;
                n_rem  = '0;
                n_step = '0;
            end
            BK_DIV: begin
                n_rem  = rem_ge ? (rem_sh - {1'b0, r_div}) : rem_sh;
                n_quo  = {r_quo[TOTAL_W-2:0], rem_ge};
                n_step = r_step + STEP_W'(1);
                n_root = '0;
                n_bit  = BIT_W'(SAMPLE_W - 1);
            end
            BK_ROOT: begin
                if (trial_sq <= r_quo[MEAN_W-1:0]) begin
                    n_root = trial;
                end
                n_bit = r_bit - BIT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (r_step == STEP_W'(TOTAL_W - 1)) begin
                    n_state = BK_ROOT;
                end
            end
            BK_ROOT: begin
                if (r_bit == '0) begin
                    n_state = BK_WRITE;
                end
            end
            BK_WRITE: begin
                if (!i_out_full) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_job_pop                  = 1'b0;
        o_out_push                 = 1'b0;
        o_out_data.peak_to_peak    = r_p2p;
        o_out_data.rms_value       = r_zero ? '0 : r_root;
        o_out_data.record_too_long = r_too_long;
        case (r_state)
            BK_IDLE:  o_job_pop  = i_job_valid;
            BK_WRITE: o_out_push = !i_out_full;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_step <= n_step;
        r_root <= n_root;
        r_bit  <= n_bit;
        if (o_job_pop) begin
            r_div      <= i_job.count;
            r_p2p      <= (i_job.count == '0) ? '0 : i_job.p2p;
            r_too_long <= i_job.too_long;
            r_zero     <= (i_job.count == '0);
        end
    end

endmodule

>>> hdl/record_peak_to_peak_and_rms.sv
// Top level: peak-to-peak and RMS measurement over records of samples.
//
//   Channel   Direction  Handshake          Payload
//   samples   in         push / full        i_sample_item (sample, last)
//   results   out        pop / empty        o_result (peak_to_peak, rms_value,
//                                           record_too_long)
//
// Samples are taken one per cycle while full is low; the accumulator needs
// no stall of its own. For each record the back end picks up the job, runs
// the restoring divide of the sum of squares by the count, takes the square
// root and writes the result.
// Two finished records can wait for the back end; full rises only when both
// places are taken. Reset is synchronous and clears all control state.
module record_peak_to_peak_and_rms
    import rpr_pkg::*;
#(
    parameter int MAX_SAMPLES = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_sample_item,
    input  logic      pop,
    output logic      empty,
    output t_out_item o_result
);

    logic      in_accept;
    logic      job_push;
    t_job      job_in;
    logic      job_full;
    logic      job_pop;
    t_job      job_out;
    logic      job_empty;
    logic      out_push;
    t_out_item out_data;
    logic      out_full;

    assign full      = job_full;
    assign in_accept = push && !job_full;

    rpr_front #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_item     (i_sample_item),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    rpr_fifo #(
        .t_data(t_job)
    ) u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    rpr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_out_data  (out_data)
    );

    rpr_fifo #(
        .t_data(t_out_item)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_data),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

    // The back end only writes a result when the result queue has room.
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> !out_full)
        else $error("result written into a full queue");

    // A job is only taken when one is waiting.
    a_job_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> !job_empty)
        else $error("job taken from an empty queue");

    // A written result is visible at the port on the next cycle.
    a_result_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |=> !empty)
        else $error("written result not visible");

    // The back end cannot finish a job in the cycle it picks one up.
    a_no_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> !out_push)
        else $error("job pickup and result write in one cycle");

endmodule
